>>> rtl/core/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared constants, types and helpers of the triangular matrix product core.
// ----------------------------------------------------------------------------
package tmps_pkg;
	localparam int MAX_SIZE  = 32;
	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 64;
	localparam int CFG_W     = 6;
	localparam int CELLS     = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int IDX_W     = $clog2(MAX_SIZE);
	localparam int SIZE_W    = $clog2(MAX_SIZE + 1);

	localparam logic signed [ACC_W-1:0] ELEM_MAX = (ACC_W'(1) <<< (ELEM_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ELEM_MIN = -ELEM_MAX - ACC_W'(1);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef struct packed {
		logic              ld_we;
		logic [ADDR_W-1:0] ld_addr;
		logic              iss_v;
		logic              iss_first;
		logic              iss_last;
		logic              iss_ph2;
		logic              iss_grp2;
		logic [ADDR_W-1:0] x_addr;
		logic [ADDR_W-1:0] y_addr;
		logic [ADDR_W-1:0] dst_addr;
		logic              sq_clr;
		logic [ADDR_W-1:0] rd_addr;
		logic              out_empty;
	} tmps_cmd_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic [SIZE_W-1:0] n);
		cell_addr = ADDR_W'(r) * ADDR_W'(n) + ADDR_W'(c);
	endfunction
endpackage

>>> rtl/core/tmps_ram.sv
// ----------------------------------------------------------------------------
// tmps_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module tmps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/tmps_dp.sv
// ----------------------------------------------------------------------------
// tmps_dp
// Datapath: element stores, multiply-accumulate pipeline, saturation.
// ----------------------------------------------------------------------------
module tmps_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tmps_pkg::tmps_cmd_t              cmd,
	input  logic signed [tmps_pkg::ELEM_W-1:0] a_element,
	input  logic signed [tmps_pkg::ELEM_W-1:0] b_element,
	output logic signed [tmps_pkg::ELEM_W-1:0] c_element,
	output logic                             overflow
);
	import tmps_pkg::*;

	logic [ELEM_W-1:0] a0_q, a1_q, b_q, s_q;
	logic [ELEM_W:0]   c_q;
	logic [ADDR_W-1:0] a0_raddr, b_raddr;

	logic              v_s1, first_s1, last_s1, ph2_s1, grp2_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic              v_s2, first_s2, last_s2, ph2_s2;
	logic [ADDR_W-1:0] dst_s2;
	logic signed [2*ELEM_W-1:0] prod_s2;
	logic              done_s3, ph2_s3;
	logic [ADDR_W-1:0] dst_s3;
	logic signed [ACC_W-1:0] acc_q, term;
	logic signed [ELEM_W-1:0] x, y, sat_val;
	logic              sat, sq_sat_q;

	assign a0_raddr = cmd.iss_ph2 ? cmd.y_addr : cmd.x_addr;
	assign b_raddr  = cmd.iss_grp2 ? cmd.x_addr : cmd.y_addr;

	tmps_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a0 (.clk(clk), .we(cmd.ld_we),
		.waddr(cmd.ld_addr), .wdata(a_element), .raddr(a0_raddr), .rdata(a0_q));
	tmps_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a1 (.clk(clk), .we(cmd.ld_we),
		.waddr(cmd.ld_addr), .wdata(a_element), .raddr(cmd.y_addr), .rdata(a1_q));
	tmps_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_b (.clk(clk), .we(cmd.ld_we),
		.waddr(cmd.ld_addr), .wdata(b_element), .raddr(b_raddr), .rdata(b_q));
	tmps_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_s (.clk(clk), .we(done_s3 && !ph2_s3),
		.waddr(dst_s3), .wdata(sat_val), .raddr(cmd.x_addr), .rdata(s_q));
	tmps_ram #(.WIDTH(ELEM_W + 1), .DEPTH(CELLS)) u_c (.clk(clk), .we(done_s3 && ph2_s3),
		.waddr(dst_s3), .wdata({sat, sat_val}), .raddr(cmd.rd_addr), .rdata(c_q));

	// operand select
	always_comb begin
		if (!ph2_s1) begin
			x = a0_q;
			y = a1_q;
		end else if (!grp2_s1) begin
			x = s_q;
			y = b_q;
		end else begin
			x = b_q;
			y = a0_q;
		end
	end

	assign term = ACC_W'(signed'(prod_s2 >>> FRAC_BITS));

	always_comb begin
		sat     = 1'b0;
		sat_val = ELEM_W'(acc_q);
		if (acc_q > ELEM_MAX) begin
			sat     = 1'b1;
			sat_val = ELEM_W'(ELEM_MAX);
		end else if (acc_q < ELEM_MIN) begin
			sat     = 1'b1;
			sat_val = ELEM_W'(ELEM_MIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			done_s3  <= 1'b0;
			sq_sat_q <= 1'b0;
		end else begin
			v_s1    <= cmd.iss_v;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_s2;
			if (cmd.sq_clr) begin
				sq_sat_q <= 1'b0;
			end else if (done_s3 && !ph2_s3 && sat) begin
				sq_sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.iss_first;
		last_s1  <= cmd.iss_last;
		ph2_s1   <= cmd.iss_ph2;
		grp2_s1  <= cmd.iss_grp2;
		dst_s1   <= cmd.dst_addr;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ph2_s2   <= ph2_s1;
		dst_s2   <= dst_s1;
		prod_s2  <= x * y;
		ph2_s3   <= ph2_s2;
		dst_s3   <= dst_s2;
		if (v_s2) begin
			acc_q <= first_s2 ? term : acc_q + term;
		end
	end

	assign c_element = cmd.out_empty ? '0 : signed'(c_q[ELEM_W-1:0]);
	assign overflow  = !cmd.out_empty && (c_q[ELEM_W] || sq_sat_q);
endmodule

>>> rtl/core/tmps_ctrl.sv
// ----------------------------------------------------------------------------
// tmps_ctrl
// Controller: load and fetch sequencing, loop counters of both products.
// ----------------------------------------------------------------------------
module tmps_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic                       last_load,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tmps_pkg::CFG_W-1:0] cfg_data,
	output tmps_pkg::tmps_cmd_t        cmd,
	output logic                       strobe,
	output logic                       last_result,
	output logic                       empty_res
);
	import tmps_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SQ       = 3'd1;
	localparam logic [2:0] ST_SQ_DRAIN = 3'd2;
	localparam logic [2:0] ST_CP       = 3'd3;
	localparam logic [2:0] ST_CP_DRAIN = 3'd4;
	localparam logic [2:0] ST_F_RD     = 3'd5;
	localparam logic [2:0] ST_F_OUT    = 3'd6;
	localparam logic [2:0] DRAIN_CYC   = 3'd5;

	logic [2:0]        state_q, drain_q;
	logic [CFG_W-1:0]  size_q;
	logic [SIZE_W-1:0] n_in, n_q;
	logic [CNT_W-1:0]  cells_in, cells_q, load_pos_q;
	logic [ADDR_W-1:0] fetch_pos_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q, nm1;
	logic              g_q, ready_q, last_q, empty_q, accept;

	always_comb begin
		if (size_q == '0) begin
			n_in = SIZE_W'(1);
		end else if (int'(size_q) > MAX_SIZE) begin
			n_in = SIZE_W'(MAX_SIZE);
		end else begin
			n_in = SIZE_W'(size_q);
		end
	end

	assign cells_in  = CNT_W'(n_in) * CNT_W'(n_in);
	assign cells_q   = CNT_W'(n_q) * CNT_W'(n_q);
	assign nm1       = IDX_W'(n_q - SIZE_W'(1));
	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd           = '0;
		cmd.ld_we     = accept && command == CMD_LOAD && load_pos_q < cells_in;
		cmd.ld_addr   = load_pos_q[ADDR_W-1:0];
		cmd.iss_ph2   = state_q == ST_CP;
		cmd.iss_grp2  = (state_q == ST_CP) && g_q;
		cmd.rd_addr   = fetch_pos_q;
		cmd.out_empty = empty_q;
		cmd.sq_clr    = accept && command == CMD_LOAD && last_load;
		cmd.dst_addr  = cell_addr(i_q, j_q, n_q);
		cmd.x_addr    = cell_addr(i_q, k_q, n_q);
		cmd.y_addr    = cell_addr(k_q, j_q, n_q);
		case (state_q)
			ST_SQ: begin
				cmd.iss_v     = 1'b1;
				cmd.iss_first = k_q == i_q;
				cmd.iss_last  = k_q == j_q;
			end
			ST_CP: begin
				cmd.iss_v     = 1'b1;
				cmd.iss_first = !g_q && k_q == i_q;
				cmd.iss_last  = g_q && k_q == nm1;
				if (g_q) begin
					cmd.y_addr = cell_addr(j_q, k_q, n_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign strobe      = state_q == ST_F_OUT;
	assign last_result = last_q && !empty_q;
	assign empty_res   = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= CFG_W'(MAX_SIZE);
			n_q         <= '0;
			load_pos_q  <= '0;
			fetch_pos_q <= '0;
			ready_q     <= 1'b0;
			drain_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			g_q         <= 1'b0;
			last_q      <= 1'b0;
			empty_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_LOAD) begin
						if (last_load) begin
							n_q         <= n_in;
							load_pos_q  <= '0;
							fetch_pos_q <= '0;
							ready_q     <= 1'b0;
							i_q         <= '0;
							j_q         <= '0;
							k_q         <= '0;
							state_q     <= ST_SQ;
						end else if (load_pos_q < cells_in) begin
							load_pos_q <= load_pos_q + CNT_W'(1);
						end
					end else if (accept) begin
						empty_q <= !ready_q;
						state_q <= ready_q ? ST_F_RD : ST_F_OUT;
					end
				end
				ST_SQ: begin
					if (k_q == j_q) begin
						if (j_q == nm1) begin
							if (i_q == nm1) begin
								drain_q <= DRAIN_CYC;
								state_q <= ST_SQ_DRAIN;
							end else begin
								i_q <= i_q + IDX_W'(1);
								j_q <= i_q + IDX_W'(1);
								k_q <= i_q + IDX_W'(1);
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
							k_q <= i_q;
						end
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_SQ_DRAIN: begin
					drain_q <= drain_q - 3'd1;
					if (drain_q == '0) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						g_q     <= 1'b0;
						state_q <= ST_CP;
					end
				end
				ST_CP: begin
					if (k_q != nm1) begin
						k_q <= k_q + IDX_W'(1);
					end else if (!g_q) begin
						g_q <= 1'b1;
						k_q <= j_q;
					end else begin
						g_q <= 1'b0;
						if (j_q == nm1) begin
							j_q <= '0;
							if (i_q == nm1) begin
								drain_q <= DRAIN_CYC;
								state_q <= ST_CP_DRAIN;
							end else begin
								i_q <= i_q + IDX_W'(1);
								k_q <= i_q + IDX_W'(1);
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
							k_q <= i_q;
						end
					end
				end
				ST_CP_DRAIN: begin
					drain_q <= drain_q - 3'd1;
					if (drain_q == '0) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_F_RD: begin
					if (CNT_W'(fetch_pos_q) + CNT_W'(1) >= cells_q) begin
						last_q      <= 1'b1;
						ready_q     <= 1'b0;
						fetch_pos_q <= '0;
					end else begin
						last_q      <= 1'b0;
						fetch_pos_q <= fetch_pos_q + ADDR_W'(1);
					end
					state_q <= ST_F_OUT;
				end
				ST_F_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/core/triangular_matrix_product_sum_core.sv
// ----------------------------------------------------------------------------
// triangular_matrix_product_sum_core
// Computes C = A*A*B + B*A^T in signed Q16.16 for an upper triangular A.
// ----------------------------------------------------------------------------
// The load marked last_load keeps busy high while one shared
// multiply-accumulate unit computes A*A, then C, and then drains its pipeline.
// A fetch passes a read state, set by the registered read of the result
// memory, and then an output state (the read state is skipped when nothing is
// pending); its result shows on the result ports for exactly one cycle marked
// by strobe, and must be taken then.
module triangular_matrix_product_sum_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic signed [tmps_pkg::ELEM_W-1:0] a_element,
	input  logic signed [tmps_pkg::ELEM_W-1:0] b_element,
	input  logic                               last_load,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmps_pkg::CFG_W-1:0]         cfg_data,
	output logic                               strobe,
	output logic signed [tmps_pkg::ELEM_W-1:0] c_element,
	output logic                               last_result,
	output logic                               overflow,
	output logic                               empty_res
);
	import tmps_pkg::*;

	tmps_cmd_t cmd;

	tmps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.last_load(last_load), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .cmd(cmd), .strobe(strobe), .last_result(last_result),
		.empty_res(empty_res)
	);

	tmps_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .a_element(a_element),
		.b_element(b_element), .c_element(c_element), .overflow(overflow)
	);
endmodule

>>> rtl/core/tmps_checker.sv
// ----------------------------------------------------------------------------
// tmps_checker
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
module tmps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               command,
	input logic                               last_load,
	input logic                               strobe,
	input logic signed [tmps_pkg::ELEM_W-1:0] c_element,
	input logic                               last_result,
	input logic                               overflow,
	input logic                               empty_res
);
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe held");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == tmps_pkg::CMD_FETCH || last_load) |=> busy)
		else $error("no busy after transfer");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result while idle");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && empty_res |-> c_element == '0 && !last_result && !overflow)
		else $error("empty result not clean");
endmodule

bind triangular_matrix_product_sum_core tmps_checker u_tmps_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
	.last_load(last_load), .strobe(strobe),
	.c_element(c_element), .last_result(last_result), .overflow(overflow),
	.empty_res(empty_res)
);
